// ----- rtl/lvbi_pkg.sv -----
// ----------------------------------------------------------------------------
// lvbi_pkg
// Types, code-word constants and small decode helpers shared by the
// LaserDisc VBI field decoder.
// ----------------------------------------------------------------------------
package lvbi_pkg;

  // Input beat: three VBI line words of one field
  typedef struct packed {
    logic [23:0] line16;
    logic [23:0] line17;
    logic [23:0] line18;
    logic        lines_present;
  } in_t;

  // Output beat: decoded field
  typedef struct packed {
    logic [8:0]  valid_flags;
    logic [16:0] frame_number;
    logic [6:0]  chapter_no;
    logic [3:0]  clv_hours;
    logic [6:0]  clv_minutes;
    logic [5:0]  clv_seconds;
    logic [4:0]  clv_picture;
    logic [9:0]  status_bits;
    logic [3:0]  audio_mode;
    logic [3:0]  am2_audio_mode;
    logic [14:0] user_word;
  } out_t;

  // Per-line classification of line 17 or line 18
  typedef struct packed {
    logic        cav_ok;
    logic        chap_ok;
    logic        hm_ok;
    logic [18:0] pic_bcd;
    logic [6:0]  chap_bcd;
    logic [3:0]  hours;
    logic [7:0]  mins_bcd;
  } line_cls_t;

  // Valid flag bit positions
  localparam int unsigned FlagData    = 0;
  localparam int unsigned FlagPicture = 1;
  localparam int unsigned FlagChapter = 2;
  localparam int unsigned FlagClv     = 3;
  localparam int unsigned FlagLeadIn  = 4;
  localparam int unsigned FlagLeadOut = 5;
  localparam int unsigned FlagStop    = 6;
  localparam int unsigned FlagStatus  = 7;
  localparam int unsigned FlagUser    = 8;

  // Code words and masks
  localparam logic [23:0] HmMask      = 24'hF0FF00;
  localparam logic [23:0] HmCode      = 24'hF0DD00;
  localparam logic [23:0] SpMask      = 24'hF0F000;
  localparam logic [23:0] SpCode      = 24'h80E000;
  localparam logic [23:0] ChapMask    = 24'hF00FFF;
  localparam logic [23:0] ChapCode    = 24'h800DDD;
  localparam logic [23:0] LeadInCode  = 24'h88FFFF;
  localparam logic [23:0] LeadOutCode = 24'h80EEEE;
  localparam logic [23:0] StopCode    = 24'h82CFFF;
  localparam logic [23:0] StatMask    = 24'hFFF000;
  localparam logic [23:0] StatCode    = 24'h8DC000;
  localparam logic [23:0] StatAmCode  = 24'h8BA000;
  localparam logic [23:0] UserMask    = 24'hF0F000;
  localparam logic [23:0] UserCode    = 24'h80D000;
  localparam logic [23:0] CxMask      = 24'h0FF000;
  localparam logic [23:0] CxCode      = 24'h0DC000;
  localparam logic [3:0]  CavPrefix   = 4'hF;
  localparam logic [3:0]  SecTensBase = 4'hA;

  // Sound mode codes
  localparam logic [3:0] SndStereo       = 4'd0;
  localparam logic [3:0] SndMono         = 4'd1;
  localparam logic [3:0] SndFuture       = 4'd2;
  localparam logic [3:0] SndBilingual    = 4'd3;
  localparam logic [3:0] SndStereoStereo = 4'd4;
  localparam logic [3:0] SndStereoBiling = 4'd5;
  localparam logic [3:0] SndCrossStereo  = 4'd6;
  localparam logic [3:0] SndBilingBiling = 4'd7;
  localparam logic [3:0] SndMonoDump     = 4'd8;
  localparam logic [3:0] SndStereoDump   = 4'd9;
  localparam logic [3:0] SndBilingDump   = 4'd10;

  // True when a nibble is a legal BCD digit
  function automatic logic nib_ok(input logic [3:0] d);
    return d <= 4'd9;
  endfunction

  // Two BCD digits to binary
  function automatic logic [6:0] bcd2_to_bin(input logic [7:0] b);
    logic [6:0] hi;
    hi = {3'b000, b[7:4]};
    return (hi << 3) + (hi << 1) + {3'b000, b[3:0]};
  endfunction

  // Programme sound table: {dump, fm, mode}
  function automatic logic [5:0] prog_sound(input logic [3:0] as);
    logic [5:0] r;
    case (as)
      4'd0:    r = {2'b00, SndStereo};
      4'd1:    r = {2'b00, SndMono};
      4'd2:    r = {2'b00, SndFuture};
      4'd3:    r = {2'b00, SndBilingual};
      4'd4:    r = {2'b01, SndStereoStereo};
      4'd5:    r = {2'b01, SndStereoBiling};
      4'd6:    r = {2'b01, SndCrossStereo};
      4'd7:    r = {2'b01, SndBilingBiling};
      4'd8:    r = {2'b10, SndMonoDump};
      4'd9:    r = {2'b10, SndMonoDump};
      4'd10:   r = {2'b10, SndFuture};
      4'd11:   r = {2'b10, SndMonoDump};
      4'd12:   r = {2'b11, SndStereoDump};
      4'd13:   r = {2'b11, SndStereoDump};
      4'd14:   r = {2'b11, SndBilingDump};
      default: r = {2'b11, SndBilingDump};
    endcase
    return r;
  endfunction

  // Amendment 2 sound table: {video standard, mode}
  function automatic logic [4:0] am2_sound(input logic [3:0] x4);
    logic [4:0] r;
    case (x4)
      4'd0:    r = {1'b1, SndStereo};
      4'd1:    r = {1'b1, SndMono};
      4'd3:    r = {1'b1, SndBilingual};
      4'd8:    r = {1'b1, SndMonoDump};
      default: r = {1'b0, SndFuture};
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/lvbi_line_class.sv -----
// ----------------------------------------------------------------------------
// lvbi_line_class
// Classifies one line 17/18 word: CAV picture, chapter and CLV hours/minutes
// codes, with BCD digit checks, and extracts the raw digit fields.
// ----------------------------------------------------------------------------
module lvbi_line_class (
  input  logic [23:0]              line_i,
  output lvbi_pkg::line_cls_t      cls_o
);

  // Match patterns and check digits
  always_comb begin
    cls_o.cav_ok   = (line_i[23:20] == lvbi_pkg::CavPrefix) &&
                     lvbi_pkg::nib_ok(line_i[15:12]) &&
                     lvbi_pkg::nib_ok(line_i[11:8]) &&
                     lvbi_pkg::nib_ok(line_i[7:4]) &&
                     lvbi_pkg::nib_ok(line_i[3:0]);
    cls_o.chap_ok  = ((line_i & lvbi_pkg::ChapMask) == lvbi_pkg::ChapCode) &&
                     lvbi_pkg::nib_ok(line_i[15:12]);
    cls_o.hm_ok    = ((line_i & lvbi_pkg::HmMask) == lvbi_pkg::HmCode) &&
                     lvbi_pkg::nib_ok(line_i[19:16]) &&
                     lvbi_pkg::nib_ok(line_i[7:4]) &&
                     lvbi_pkg::nib_ok(line_i[3:0]);
    cls_o.pic_bcd  = line_i[18:0];
    cls_o.chap_bcd = line_i[18:12];
    cls_o.hours    = line_i[19:16];
    cls_o.mins_bcd = line_i[7:0];
  end

endmodule

// ----- rtl/laserdisc_vbi_field_decoder_core.sv -----
// ----------------------------------------------------------------------------
// laserdisc_vbi_field_decoder_core
// Decodes the biphase VBI words of lines 16, 17 and 18 of one video field.
// ----------------------------------------------------------------------------
// The core accepts one field per clock unless output back-pressure has
// filled the pipe, and presents the decoded beats on the output in order.
// It is built as a four-register pipeline: input capture, code matching
// and digit checks, BCD-to-binary conversion, and final field gating in
// the output register. Each stage advances when the stage after it is
// empty or moving, so back-pressure on the output stalls the pipe without
// dropping or repeating a beat, and the input stays ready while the output
// register holds a result and an earlier stage is free. Line 18 takes
// priority over line 17 when both carry a valid code.
module laserdisc_vbi_field_decoder_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lvbi_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lvbi_pkg::out_t  out_data_o
);

  // Stage 2 payload: classification and raw digits
  typedef struct packed {
    logic        present;
    logic        cav_ok;
    logic        chap_ok;
    logic        hm_ok;
    logic        sp_ok;
    logic        lead_in;
    logic        lead_exit;
    logic        stop;
    logic        stat_hit;
    logic        user_hit;
    logic [18:0] pic_bcd;
    logic [6:0]  chap_bcd;
    logic [3:0]  hours;
    logic [7:0]  mins_bcd;
    logic [2:0]  sec_tens;
    logic [3:0]  sec_units;
    logic [7:0]  cpic_bcd;
    logic [9:0]  status;
    logic [3:0]  snd;
    logic [3:0]  am2;
    logic [14:0] ucode;
  } cls_t;

  // Stage 3 payload: binary values and flags
  typedef struct packed {
    logic [8:0]  flags;
    logic [16:0] pic;
    logic [6:0]  chap;
    logic [3:0]  hours;
    logic [6:0]  mins;
    logic [5:0]  secs;
    logic [4:0]  cpic;
    logic [9:0]  status;
    logic [3:0]  snd;
    logic [3:0]  am2;
    logic [14:0] ucode;
  } bin_t;

  logic           v1_q, v2_q, v3_q, v4_q;
  logic           ld1, ld2, ld3, ld4;
  lvbi_pkg::in_t  s1_q;
  cls_t           s2_d, s2_q;
  bin_t           s3_d, s3_q;
  lvbi_pkg::out_t s4_d, s4_q;

  lvbi_pkg::line_cls_t c17, c18;

  // Stage load enables: load when empty or when the next stage moves
  assign ld4        = !v4_q || out_ready_i;
  assign ld3        = !v3_q || ld4;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_ready_o = ld1;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (ld1) s1_q <= in_data_i;
    if (ld2) s2_q <= s2_d;
    if (ld3) s3_q <= s3_d;
    if (ld4) s4_q <= s4_d;
  end

  // Stage 1: classify lines 17 and 18
  lvbi_line_class u_cls17 (
    .line_i (s1_q.line17),
    .cls_o  (c17)
  );

  lvbi_line_class u_cls18 (
    .line_i (s1_q.line18),
    .cls_o  (c18)
  );

  // Stage 1: merge lines, decode line 16
  always_comb begin
    logic [23:0] l16;
    logic [3:0]  x3, x4, x5;
    logic [5:0]  ps;
    logic [4:0]  a2;
    logic        par;
    l16 = s1_q.line16;
    x3  = l16[11:8];
    x4  = l16[7:4];
    x5  = l16[3:0];
    ps  = lvbi_pkg::prog_sound({x4[3], x3[0], x4[1:0]});
    a2  = lvbi_pkg::am2_sound(x4);
    par = ((x4[3] ^ x4[2] ^ x4[0]) == x5[3]) &&
          ((x4[3] ^ x4[1] ^ x4[0]) == x5[2]) &&
          ((x4[2] ^ x4[1] ^ x4[0]) == x5[1]);

    s2_d.present  = s1_q.lines_present;
    s2_d.cav_ok   = c17.cav_ok || c18.cav_ok;
    s2_d.chap_ok  = c17.chap_ok || c18.chap_ok;
    s2_d.hm_ok    = c17.hm_ok || c18.hm_ok;
    s2_d.pic_bcd  = c18.cav_ok ? c18.pic_bcd : c17.pic_bcd;
    s2_d.chap_bcd = c18.chap_ok ? c18.chap_bcd : c17.chap_bcd;
    s2_d.hours    = c18.hm_ok ? c18.hours : c17.hours;
    s2_d.mins_bcd = c18.hm_ok ? c18.mins_bcd : c17.mins_bcd;

    // CLV seconds and picture: tens coded from 0xA, picture below 30
    s2_d.sp_ok     = ((l16 & lvbi_pkg::SpMask) == lvbi_pkg::SpCode) &&
                     (l16[19:16] >= lvbi_pkg::SecTensBase) &&
                     lvbi_pkg::nib_ok(l16[11:8]) &&
                     lvbi_pkg::nib_ok(l16[3:0]) &&
                     (l16[7:4] <= 4'd2);
    s2_d.sec_tens  = 3'(l16[19:16] - lvbi_pkg::SecTensBase);
    s2_d.sec_units = l16[11:8];
    s2_d.cpic_bcd  = l16[7:0];

    s2_d.lead_in   = (s1_q.line17 == lvbi_pkg::LeadInCode) ||
                     (s1_q.line18 == lvbi_pkg::LeadInCode);
    s2_d.lead_exit = (s1_q.line17 == lvbi_pkg::LeadOutCode) ||
                     (s1_q.line18 == lvbi_pkg::LeadOutCode);
    s2_d.stop      = (l16 == lvbi_pkg::StopCode) ||
                     (s1_q.line17 == lvbi_pkg::StopCode);

    // Programme status
    s2_d.stat_hit = ((l16 & lvbi_pkg::StatMask) == lvbi_pkg::StatCode) ||
                    ((l16 & lvbi_pkg::StatMask) == lvbi_pkg::StatAmCode);
    s2_d.status   = {a2[4], x3[0], ps[5], ps[4], x4[2], x3[1], !x3[2], !x3[3],
                     par, ((l16 & lvbi_pkg::CxMask) == lvbi_pkg::CxCode)};
    s2_d.snd      = ps[3:0];
    s2_d.am2      = a2[3:0];

    // User code: first digit limited to three bits
    s2_d.user_hit = ((l16 & lvbi_pkg::UserMask) == lvbi_pkg::UserCode) && !l16[19];
    s2_d.ucode    = {l16[18:16], l16[11:0]};
  end

  // Stage 2: BCD to binary, build flags
  always_comb begin
    logic [16:0] d4, d3, d2, d1, d0;
    logic [5:0]  tens;
    logic        p;
    d4 = {14'd0, s2_q.pic_bcd[18:16]};
    d3 = {13'd0, s2_q.pic_bcd[15:12]};
    d2 = {13'd0, s2_q.pic_bcd[11:8]};
    d1 = {13'd0, s2_q.pic_bcd[7:4]};
    d0 = {13'd0, s2_q.pic_bcd[3:0]};
    tens = {3'd0, s2_q.sec_tens};
    p    = s2_q.present;

    s3_d.pic    = d4 * 17'd10000 + d3 * 17'd1000 + d2 * 17'd100 +
                  d1 * 17'd10 + d0;
    s3_d.chap   = lvbi_pkg::bcd2_to_bin({1'b0, s2_q.chap_bcd});
    s3_d.hours  = s2_q.hours;
    s3_d.mins   = lvbi_pkg::bcd2_to_bin(s2_q.mins_bcd);
    s3_d.secs   = (tens << 3) + (tens << 1) + {2'd0, s2_q.sec_units};
    s3_d.cpic   = 5'(lvbi_pkg::bcd2_to_bin(s2_q.cpic_bcd));
    s3_d.status = s2_q.status;
    s3_d.snd    = s2_q.snd;
    s3_d.am2    = s2_q.am2;
    s3_d.ucode  = s2_q.ucode;

    s3_d.flags                        = '0;
    s3_d.flags[lvbi_pkg::FlagData]    = p;
    s3_d.flags[lvbi_pkg::FlagPicture] = p && s2_q.cav_ok && !s2_q.sp_ok;
    s3_d.flags[lvbi_pkg::FlagChapter] = p && s2_q.chap_ok;
    s3_d.flags[lvbi_pkg::FlagClv]     = p && s2_q.hm_ok && s2_q.sp_ok;
    s3_d.flags[lvbi_pkg::FlagLeadIn]  = p && s2_q.lead_in;
    s3_d.flags[lvbi_pkg::FlagLeadOut] = p && s2_q.lead_exit;
    s3_d.flags[lvbi_pkg::FlagStop]    = p && s2_q.stop;
    s3_d.flags[lvbi_pkg::FlagStatus]  = p && s2_q.stat_hit;
    s3_d.flags[lvbi_pkg::FlagUser]    = p && s2_q.user_hit;
  end

  // Stage 3: drop fields whose flag is clear
  always_comb begin
    logic fc, fs;
    fc = s3_q.flags[lvbi_pkg::FlagClv];
    fs = s3_q.flags[lvbi_pkg::FlagStatus];
    s4_d.valid_flags    = s3_q.flags;
    s4_d.frame_number   = s3_q.flags[lvbi_pkg::FlagPicture] ? s3_q.pic : '0;
    s4_d.chapter_no     = s3_q.flags[lvbi_pkg::FlagChapter] ? s3_q.chap : '0;
    s4_d.clv_hours      = fc ? s3_q.hours : '0;
    s4_d.clv_minutes    = fc ? s3_q.mins : '0;
    s4_d.clv_seconds    = fc ? s3_q.secs : '0;
    s4_d.clv_picture    = fc ? s3_q.cpic : '0;
    s4_d.status_bits    = fs ? s3_q.status : '0;
    s4_d.audio_mode     = fs ? s3_q.snd : '0;
    s4_d.am2_audio_mode = fs ? s3_q.am2 : '0;
    s4_d.user_word      = s3_q.flags[lvbi_pkg::FlagUser] ? s3_q.ucode : '0;
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = s4_q;

endmodule

// ----- rtl/lvbi_checker.sv -----
// ----------------------------------------------------------------------------
// lvbi_checker
// Port-level checks for the VBI field decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lvbi_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input lvbi_pkg::out_t  out_data_o
);

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // Input stalls only under output back-pressure
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without output back-pressure");

  // A beat without data carries nothing
  a_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_flags[lvbi_pkg::FlagData] |-> out_data_o == '0)
    else $error("beat without data has nonzero fields");

  // CAV picture and CLV time code exclude each other
  a_cav_clv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.valid_flags[lvbi_pkg::FlagPicture] &&
                      out_data_o.valid_flags[lvbi_pkg::FlagClv]))
    else $error("picture number and CLV time code both flagged");

endmodule

bind laserdisc_vbi_field_decoder_core lvbi_checker u_lvbi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- test/laserdisc_vbi_field_decoder_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// laserdisc_vbi_field_decoder_core_test
// Self-checking bench for the VBI field decoder. Directed fields cover the
// code-word extremes and priority rules. Random fields follow, mostly
// well-formed code words with random digits, with idle bursts on both ports.
// A behavioral decoder predicts each beat and a scoreboard checks every field.
// ----------------------------------------------------------------------------
module laserdisc_vbi_field_decoder_core_test;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned MaxPrinted  = 40;

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lvbi_pkg::in_t  in_data  = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lvbi_pkg::out_t out_data;

  bit             idle_on = 1'b1;
  int unsigned    error_count = 0;
  int unsigned    beat_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    sink_stall = 0;
  lvbi_pkg::out_t decoded_q[$];
  lvbi_pkg::out_t want;

  laserdisc_vbi_field_decoder_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Free-running clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("laserdisc_vbi_field_decoder_core_test: errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Behavioral decoder
  // ------------------------------------------------------------------------

  // Convert n BCD nibbles of v; fail on any nibble above nine
  function automatic bit bcd_digits(input logic [19:0] v, input int unsigned n,
                                    output int unsigned val);
    int unsigned acc;
    int unsigned scale;
    int unsigned i;
    logic [3:0]  d;
    acc = 0;
    scale = 1;
    val = 0;
    for (i = 0; i < n; i++) begin
      d = v[4*i +: 4];
      if (d > 4'd9) return 1'b0;
      acc = acc + d * scale;
      scale = scale * 10;
    end
    val = acc;
    return 1'b1;
  endfunction

  // Programme audio status to {dump, fm, mode}
  function automatic logic [5:0] programme_audio(input logic [3:0] as);
    logic [5:0] r;
    case (as)
      4'd0, 4'd1, 4'd2, 4'd3: r = {2'b00, as};
      4'd4, 4'd5, 4'd6, 4'd7: r = {2'b01, as};
      4'd10:                  r = {2'b10, lvbi_pkg::SndFuture};
      4'd8, 4'd9, 4'd11:      r = {2'b10, lvbi_pkg::SndMonoDump};
      4'd12, 4'd13:           r = {2'b11, lvbi_pkg::SndStereoDump};
      default:                r = {2'b11, lvbi_pkg::SndBilingDump};
    endcase
    return r;
  endfunction

  // Amendment 2 audio to {video standard, mode}
  function automatic logic [4:0] amendment_audio(input logic [3:0] x4);
    logic [4:0] r;
    r = {1'b0, lvbi_pkg::SndFuture};
    if (x4 == 4'd0) r = {1'b1, lvbi_pkg::SndStereo};
    if (x4 == 4'd1) r = {1'b1, lvbi_pkg::SndMono};
    if (x4 == 4'd3) r = {1'b1, lvbi_pkg::SndBilingual};
    if (x4 == 4'd8) r = {1'b1, lvbi_pkg::SndMonoDump};
    return r;
  endfunction

  function automatic lvbi_pkg::out_t decode_field(input lvbi_pkg::in_t f);
    lvbi_pkg::out_t r;
    logic [23:0] w;
    logic [23:0] l16;
    logic [3:0]  x3;
    logic [3:0]  x4;
    logic [3:0]  x5;
    logic [5:0]  ps;
    logic [4:0]  a2;
    bit          cav;
    bit          hm;
    bit          sp;
    int unsigned k;
    int unsigned t;
    int unsigned u;
    int unsigned pic;
    int unsigned chap;
    int unsigned hrs;
    int unsigned mins;
    r = '0;
    cav = 1'b0;
    hm = 1'b0;
    sp = 1'b0;
    pic = 0;
    chap = 0;
    hrs = 0;
    mins = 0;
    l16 = f.line16;
    if (!f.lines_present) return r;
    r.valid_flags[lvbi_pkg::FlagData] = 1'b1;

    // Scan line 17 then line 18 so a good line 18 overrides
    for (k = 0; k < 2; k++) begin
      w = (k == 0) ? f.line17 : f.line18;
      if (w[23:20] == 4'hF && bcd_digits({1'b0, w[18:0]}, 5, t)) begin
        pic = t;
        cav = 1'b1;
      end
      if (w[23:20] == 4'h8 && w[11:0] == 12'hDDD &&
          bcd_digits({13'd0, w[18:12]}, 2, t)) begin
        chap = t;
        r.valid_flags[lvbi_pkg::FlagChapter] = 1'b1;
      end
      if (w[23:20] == 4'hF && w[15:8] == 8'hDD &&
          bcd_digits({16'd0, w[19:16]}, 1, t) &&
          bcd_digits({12'd0, w[7:0]}, 2, u)) begin
        hrs = t;
        mins = u;
        hm = 1'b1;
      end
    end

    // Seconds and picture from line 16
    if (l16[23:20] == 4'h8 && l16[15:12] == 4'hE && l16[19:16] >= 4'hA &&
        bcd_digits({16'd0, l16[11:8]}, 1, t) &&
        bcd_digits({12'd0, l16[7:0]}, 2, u) && u <= 29) begin
      sp = 1'b1;
      if (hm) begin
        r.valid_flags[lvbi_pkg::FlagClv] = 1'b1;
        r.clv_hours   = 4'(hrs);
        r.clv_minutes = 7'(mins);
        r.clv_seconds = 6'(10 * (l16[19:16] - 4'hA) + t);
        r.clv_picture = 5'(u);
      end
    end
    if (cav && !sp) begin
      r.valid_flags[lvbi_pkg::FlagPicture] = 1'b1;
      r.frame_number = 17'(pic);
    end
    if (r.valid_flags[lvbi_pkg::FlagChapter]) r.chapter_no = 7'(chap);

    if (f.line17 == 24'h88FFFF || f.line18 == 24'h88FFFF)
      r.valid_flags[lvbi_pkg::FlagLeadIn] = 1'b1;
    if (f.line17 == 24'h80EEEE || f.line18 == 24'h80EEEE)
      r.valid_flags[lvbi_pkg::FlagLeadOut] = 1'b1;
    if (l16 == 24'h82CFFF || f.line17 == 24'h82CFFF)
      r.valid_flags[lvbi_pkg::FlagStop] = 1'b1;

    // Programme status word
    if (l16[23:12] == 12'h8DC || l16[23:12] == 12'h8BA) begin
      x3 = l16[11:8];
      x4 = l16[7:4];
      x5 = l16[3:0];
      ps = programme_audio({x4[3], x3[0], x4[1:0]});
      a2 = amendment_audio(x4);
      r.valid_flags[lvbi_pkg::FlagStatus] = 1'b1;
      r.status_bits[0] = (l16[19:12] == 8'hDC);
      r.status_bits[1] = ((x4[3] ^ x4[2] ^ x4[0]) == x5[3]) &&
                         ((x4[3] ^ x4[1] ^ x4[0]) == x5[2]) &&
                         ((x4[2] ^ x4[1] ^ x4[0]) == x5[1]);
      r.status_bits[2] = ~x3[3];
      r.status_bits[3] = ~x3[2];
      r.status_bits[4] = x3[1];
      r.status_bits[5] = x4[2];
      r.status_bits[6] = ps[4];
      r.status_bits[7] = ps[5];
      r.status_bits[8] = x3[0];
      r.status_bits[9] = a2[4];
      r.audio_mode     = ps[3:0];
      r.am2_audio_mode = a2[3:0];
    end

    // User code
    if (l16[23:20] == 4'h8 && l16[15:12] == 4'hD && l16[19:16] <= 4'd7) begin
      r.valid_flags[lvbi_pkg::FlagUser] = 1'b1;
      r.user_word = {l16[18:16], l16[11:0]};
    end
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Scoreboard
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (error_count < MaxPrinted) $display("beat %0d: %s", beat_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp);
    if (got !== exp) report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp));
  endtask

  // Record accepted fields and check each returned beat against the oldest one
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) decoded_q.push_back(decode_field(in_data));
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result beat with no field outstanding");
        end else begin
          want = decoded_q.pop_front();
          check_field("valid_flags", 32'(out_data.valid_flags), 32'(want.valid_flags));
          check_field("frame_number", 32'(out_data.frame_number), 32'(want.frame_number));
          check_field("chapter_no", 32'(out_data.chapter_no), 32'(want.chapter_no));
          check_field("clv_hours", 32'(out_data.clv_hours), 32'(want.clv_hours));
          check_field("clv_minutes", 32'(out_data.clv_minutes), 32'(want.clv_minutes));
          check_field("clv_seconds", 32'(out_data.clv_seconds), 32'(want.clv_seconds));
          check_field("clv_picture", 32'(out_data.clv_picture), 32'(want.clv_picture));
          check_field("status_bits", 32'(out_data.status_bits), 32'(want.status_bits));
          check_field("audio_mode", 32'(out_data.audio_mode), 32'(want.audio_mode));
          check_field("am2_audio_mode", 32'(out_data.am2_audio_mode),
                      32'(want.am2_audio_mode));
          check_field("user_word", 32'(out_data.user_word), 32'(want.user_word));
        end
        beat_count++;
      end
    end
  end

  // Stall the result port in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (sink_stall != 0) begin
      sink_stall <= sink_stall - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      sink_stall <= $urandom_range(0, 7);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Offer one field and hold it until the beat is taken
  task automatic send_field(input lvbi_pkg::in_t field);
    bit          ready_seen;
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= field;
    ready_seen = 1'b0;
    while (!ready_seen) begin
      @(negedge clk);
      ready_seen = in_ready;
      @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every outstanding field has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (decoded_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic lvbi_pkg::in_t make_field(input logic [23:0] l16,
                                               input logic [23:0] l17,
                                               input logic [23:0] l18);
    lvbi_pkg::in_t f;
    f.line16 = l16;
    f.line17 = l17;
    f.line18 = l18;
    f.lines_present = 1'b1;
    return f;
  endfunction

  // Mostly legal digits, now and then a bad one
  function automatic logic [3:0] rand_digit();
    if ($urandom_range(0, 15) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  function automatic logic [23:0] rand_line16();
    logic [3:0]  tens;
    logic [3:0]  x4;
    logic [7:0]  pic;
    int unsigned p;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        tens = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 9) :
                                                $urandom_range(10, 15));
        p = $urandom_range(0, 29);
        pic[7:4] = 4'(p / 10);
        pic[3:0] = 4'(p % 10);
        if ($urandom_range(0, 5) == 0) pic = {rand_digit(), rand_digit()};
        return {4'h8, tens, 4'hE, rand_digit(), pic};
      end
      3, 4: begin
        x4 = 4'($urandom_range(0, 15));
        return {4'h8, ($urandom_range(0, 1) != 0) ? 8'hDC : 8'hBA,
                4'($urandom_range(0, 15)), x4,
                ($urandom_range(0, 1) != 0) ?
                  {x4[3] ^ x4[2] ^ x4[0], x4[3] ^ x4[1] ^ x4[0],
                   x4[2] ^ x4[1] ^ x4[0], 1'($urandom_range(0, 1))} :
                  4'($urandom_range(0, 15))};
      end
      5, 6: return {4'h8, ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15)) :
                    4'($urandom_range(0, 7)), 4'hD, 12'($urandom_range(0, 4095))};
      7:       return 24'h82CFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_line17_18();
    case ($urandom_range(0, 9))
      0, 1: return {4'hF, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    rand_digit(), rand_digit(), rand_digit(), rand_digit()};
      2:    return {4'h8, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    rand_digit(), 12'hDDD};
      3, 4: return {4'hF, rand_digit(), 8'hDD, rand_digit(), rand_digit()};
      5:       return 24'h88FFFF;
      6:       return 24'h80EEEE;
      7:       return 24'h82CFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  task automatic test_absent_lines();
    lvbi_pkg::in_t f;
    f = make_field(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    f.lines_present = 1'b0;
    send_field(f);
    f = make_field(24'h8DC000, 24'hF12345, 24'h88FFFF);
    f.lines_present = 1'b0;
    send_field(f);
  endtask

  task automatic test_picture_number();
    send_field(make_field(24'h000000, 24'h000000, 24'h000000));
    send_field(make_field(24'h000000, 24'hF79999, 24'h000000));
    send_field(make_field(24'h000000, 24'h000000, 24'hF00000));
    // line 18 overrides line 17, unless its digits are bad
    send_field(make_field(24'h000000, 24'hF12345, 24'hF54321));
    send_field(make_field(24'h000000, 24'hF00001, 24'hF1234A));
    // seconds code on line 16 suppresses the picture number
    send_field(make_field(24'h8AE000, 24'hF12345, 24'h000000));
  endtask

  task automatic test_chapter();
    send_field(make_field(24'h000000, 24'h879DDD, 24'h800DDD));
    send_field(make_field(24'h000000, 24'h87ADDD, 24'h000000));
    send_field(make_field(24'h000000, 24'h000000, 24'h879DDD));
  endtask

  task automatic test_clv_time_code();
    send_field(make_field(24'h8FE929, 24'hF9DD99, 24'h000000));
    send_field(make_field(24'h8AE000, 24'h000000, 24'hF0DD00));
    // picture 30, tens below the offset and bad minutes all reject
    send_field(make_field(24'h8AE030, 24'hF0DD00, 24'h000000));
    send_field(make_field(24'h89E000, 24'hF1DD11, 24'h000000));
    send_field(make_field(24'h8AE000, 24'hF0DD0A, 24'h000000));
  endtask

  task automatic test_lead_and_stop_codes();
    send_field(make_field(24'h000000, 24'h88FFFF, 24'h80EEEE));
    send_field(make_field(24'h82CFFF, 24'h80EEEE, 24'h88FFFF));
    send_field(make_field(24'h000000, 24'h82CFFF, 24'h000000));
  endtask

  task automatic test_programme_status();
    send_field(make_field(24'h8DC000, 24'h000000, 24'h000000));
    send_field(make_field(24'h8DCFFF, 24'h000000, 24'h000000));
    send_field(make_field(24'h8BA538, 24'h000000, 24'h000000));
    send_field(make_field(24'h8DC9C6, 24'h000000, 24'h000000));
    send_field(make_field(24'h8BAF0E, 24'h000000, 24'h000000));
  endtask

  task automatic test_user_code();
    send_field(make_field(24'h87DFFF, 24'h000000, 24'h000000));
    send_field(make_field(24'h80D000, 24'h000000, 24'h000000));
    send_field(make_field(24'h88D123, 24'h000000, 24'h000000));
  endtask

  task automatic test_random_fields(input int unsigned count);
    lvbi_pkg::in_t f;
    int unsigned   n;
    for (n = 0; n < count; n++) begin
      f = make_field(rand_line16(), rand_line17_18(), rand_line17_18());
      if ($urandom_range(0, 15) == 0) f.lines_present = 1'b0;
      send_field(f);
    end
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_absent_lines();
    test_picture_number();
    test_chapter();
    test_clv_time_code();
    test_lead_and_stop_codes();
    test_programme_status();
    test_user_code();

    test_random_fields(150);
    wait_for_results();
    test_random_fields(150);

    // finish with both ports at full rate
    idle_on = 1'b0;
    test_random_fields(100);
    wait_for_results();

    if (error_count == 0) begin
      $display("laserdisc_vbi_field_decoder_core_test: clean");
    end else begin
      $display("laserdisc_vbi_field_decoder_core_test: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lvbi_pkg.sv
rtl/lvbi_line_class.sv
rtl/laserdisc_vbi_field_decoder_core.sv
rtl/lvbi_checker.sv
test/laserdisc_vbi_field_decoder_core_test.sv
